>>> src/hbs_pkg.sv
// Package with the shared widths, codes and types of the healthy backend selector.
`default_nettype none

package hbs_pkg;

    // Field widths of the item, result and configuration channels.
    localparam int CMD_W      = 1;
    localparam int INDEX_W    = 4;
    localparam int LOAD_W     = 10;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CHOOSE = 1'b1;

    // Strategy codes.
    localparam logic MODE_LEAST_LOAD  = 1'b0;
    localparam logic MODE_ROUND_ROBIN = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY_MODE = 2'd1;

    // One slot entry of the stats memory.
    typedef struct packed {
        logic              healthy;
        logic [LOAD_W-1:0] load;
    } slot_t;

    // Contents of a slot that was never written since reset.
    localparam slot_t SLOT_RESET = '{healthy: 1'b1, load: '0};

endpackage

`default_nettype wire

>>> src/hbs_ifs.sv
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none

interface hbs_req_if;
    logic                        valid;
    logic                        ready;
    logic [hbs_pkg::CMD_W-1:0]   command;
    logic [hbs_pkg::INDEX_W-1:0] target_index;
    logic [hbs_pkg::LOAD_W-1:0]  cpu_load;
    logic                        is_healthy;

    modport source (output valid, command, target_index, cpu_load, is_healthy, input ready);
    modport sink   (input valid, command, target_index, cpu_load, is_healthy, output ready);
endinterface

interface hbs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [hbs_pkg::INDEX_W-1:0] chosen_index;

    modport source (output valid, found, chosen_index, input ready);
    modport sink   (input valid, found, chosen_index, output ready);
endinterface

interface hbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hbs_pkg::CFG_IDX_W-1:0]  index;
    logic [hbs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/healthy_backend_selector_core.sv
// Healthy backend selector: slot stats memory with a scanning choose sequencer.
// An update leaves the input ready; a choose holds the input until its result is registered.
// A choose scans the n slots in use through the registered-read stats memory: least load
// makes one pass; round robin adds a second pass after reducing the pointer mod the healthy
// count by repeated subtraction (it acts as least load when no slot is healthy).
// Reset (rst_n, asynchronous, active low) marks all slots as never written
// (load 0, healthy), clears the pointer and the registers; no clearing pass.
`default_nettype none

module healthy_backend_selector_core #(
    parameter int MAX_TARGETS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    hbs_req_if.sink     req,
    hbs_rsp_if.source   rsp,
    hbs_cfg_if.sink     cfg
);

    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W = $clog2(MAX_TARGETS + 1);
    localparam int N_W   = (CNT_W > hbs_pkg::COUNT_W) ? CNT_W : hbs_pkg::COUNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Stats memory and its per-slot written flags.
    hbs_pkg::slot_t           mem [MAX_TARGETS];
    logic [MAX_TARGETS-1:0]   written_reg;
    hbs_pkg::slot_t           rd_slot_reg;
    logic                     rd_hit_reg;
    logic                     rd_pend_reg;
    logic [N_W-1:0]           rd_idx_reg;

    // Sequencer and configuration state.
    logic [2:0]                        state_reg, state_next;
    logic [N_W-1:0]                    issue_reg, issue_next;
    logic [N_W-1:0]                    healthy_reg, healthy_next;
    logic [hbs_pkg::LOAD_W-1:0]        best_reg, best_next;
    logic                              have_reg, have_next;
    logic [N_W-1:0]                    pick_reg, pick_next;
    logic [N_W-1:0]                    k_reg, k_next;
    logic [N_W-1:0]                    seen_reg, seen_next;
    logic [hbs_pkg::INDEX_W-1:0]       ptr_reg, ptr_next;
    logic [hbs_pkg::COUNT_W-1:0]       tc_reg, tc_next;
    logic                              mode_reg, mode_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_found_reg, out_found_next;
    logic [hbs_pkg::INDEX_W-1:0]       out_index_reg, out_index_next;

    logic [N_W-1:0]       n_use;
    logic [N_W-1:0]       tc_ext;
    logic [N_W-1:0]       upd_idx;
    logic [N_W-1:0]       k_inc;
    logic                 req_accept;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    hbs_pkg::slot_t       wr_slot;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 scan_done;
    hbs_pkg::slot_t       rd_slot;

    // Number of slots in use, capped at the memory depth.
    assign tc_ext = N_W'(tc_reg);
    assign n_use  = (tc_ext > N_W'(MAX_TARGETS)) ? N_W'(MAX_TARGETS) : tc_ext;

    // Handshakes.
    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.chosen_index = out_index_reg;

    // Update writes go straight to the memory when the slot is in use.
    assign upd_idx = N_W'(req.target_index);
    assign wr_en   = req_accept && (req.command == hbs_pkg::CMD_UPDATE) && (upd_idx < n_use);
    assign wr_addr = upd_idx[IDX_W-1:0];
    assign wr_slot = '{healthy: req.is_healthy, load: req.cpu_load};

    // Scan reads issue one slot per cycle; the scan ends when all reads have returned.
    assign rd_en     = ((state_reg == S_SCAN1) || (state_reg == S_SCAN2)) && (issue_reg < n_use);
    assign rd_addr   = issue_reg[IDX_W-1:0];
    assign scan_done = (issue_reg >= n_use) && !rd_pend_reg;
    assign rd_slot   = rd_hit_reg ? rd_slot_reg : hbs_pkg::SLOT_RESET;
    assign k_inc     = k_reg + N_W'(1);

    // Memory array: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_slot;
        end
        if (rd_en)
        begin
            rd_slot_reg <= mem[rd_addr];
        end
    end

    // Written flags and read tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_pend_reg <= rd_en;
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_addr];
                rd_idx_reg <= issue_reg;
            end
        end
    end

    // Configuration register writes.
    always_comb
    begin
        tc_next   = tc_reg;
        mode_next = mode_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                hbs_pkg::CFG_TARGET_COUNT:  tc_next   = cfg.data[hbs_pkg::COUNT_W-1:0];
                hbs_pkg::CFG_STRATEGY_MODE: mode_next = cfg.data[0];
                default:                    tc_next   = tc_reg;
            endcase
        end
    end

    // Choose sequencer: count and least-load pass, pointer reduction, round-robin pass.
    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        healthy_next   = healthy_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        pick_next      = pick_reg;
        k_next         = k_reg;
        seen_next      = seen_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept && (req.command == hbs_pkg::CMD_CHOOSE))
                begin
                    state_next   = S_SCAN1;
                    issue_next   = '0;
                    healthy_next = '0;
                    have_next    = 1'b0;
                    best_next    = '0;
                    pick_next    = '0;
                end
            end
            S_SCAN1:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + N_W'(1);
                end
                if (rd_pend_reg && rd_slot.healthy)
                begin
                    healthy_next = healthy_reg + N_W'(1);
                    if (!have_reg || (rd_slot.load < best_reg))
                    begin
                        have_next = 1'b1;
                        best_next = rd_slot.load;
                        pick_next = rd_idx_reg;
                    end
                end
                if (scan_done)
                begin
                    if ((mode_reg == hbs_pkg::MODE_ROUND_ROBIN) && (healthy_reg != '0))
                    begin
                        state_next = S_MOD;
                        k_next     = N_W'(ptr_reg);
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MOD:
            begin
                // One subtract step per cycle until the pointer is below the healthy count.
                if (k_reg >= healthy_reg)
                begin
                    k_next = k_reg - healthy_reg;
                end
                else
                begin
                    state_next = S_SCAN2;
                    issue_next = '0;
                    seen_next  = '0;
                    have_next  = 1'b0;
                    pick_next  = '0;
                    ptr_next   = (k_inc == healthy_reg) ? '0 : k_inc[hbs_pkg::INDEX_W-1:0];
                end
            end
            S_SCAN2:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + N_W'(1);
                end
                if (rd_pend_reg && rd_slot.healthy)
                begin
                    if ((seen_reg == k_reg) && !have_reg)
                    begin
                        have_next = 1'b1;
                        pick_next = rd_idx_reg;
                    end
                    seen_next = seen_reg + N_W'(1);
                end
                if (scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the output register once it is free or being emptied.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = have_reg;
                    out_index_next = have_reg ? pick_reg[hbs_pkg::INDEX_W-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer, configuration and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            healthy_reg   <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            pick_reg      <= '0;
            k_reg         <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            tc_reg        <= '0;
            mode_reg      <= hbs_pkg::MODE_LEAST_LOAD;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_index_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            healthy_reg   <= healthy_next;
            best_reg      <= best_next;
            have_reg      <= have_next;
            pick_reg      <= pick_next;
            k_reg         <= k_next;
            seen_reg      <= seen_next;
            ptr_reg       <= ptr_next;
            tc_reg        <= tc_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_index_reg <= out_index_next;
        end
    end

endmodule

`default_nettype wire

>>> src/hbs_checker.sv
// Port-level checker for the healthy backend selector and its bind statement.
`default_nettype none

module hbs_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              req_valid,
    input wire                              req_ready,
    input wire [hbs_pkg::CMD_W-1:0]         req_command,
    input wire                              rsp_valid,
    input wire                              rsp_ready,
    input wire                              rsp_found,
    input wire [hbs_pkg::INDEX_W-1:0]       rsp_chosen_index
);

    // A stalled result stays valid and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_chosen_index))
        else $error("stalled result changed");

    // A result without a chosen slot reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_chosen_index == '0)
        else $error("not-found result with nonzero index");

    // A choose transfer occupies the block, so the next cycle takes no item.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == hbs_pkg::CMD_CHOOSE) |=> !req_ready)
        else $error("item accepted during a choose scan");

    // An update transfer leaves the block ready for the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == hbs_pkg::CMD_UPDATE) |=> req_ready)
        else $error("update did not return to ready");

endmodule

bind healthy_backend_selector_core hbs_checker u_hbs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_command      (req.command),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found        (rsp.found),
    .rsp_chosen_index (rsp.chosen_index)
);

`default_nettype wire
